// File: src/nfi_pkg.sv
// Shared types and constants of the Newton forward-difference interpolator.
package nfi_pkg;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_FEW = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_X_ORIGIN    = 2'd1;
    localparam logic [1:0] REG_STEP_RECIP  = 2'd2;

    // Saturation bound of the wide internal values, 2^62 - 1.
    localparam logic [63:0] WIDE_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_READ,
        ST_LD_WRITE,
        ST_EV_SMUL,
        ST_EV_FACT,
        ST_EV_PF,
        ST_EV_PF_W,
        ST_EV_PI_W,
        ST_EV_PL_W,
        ST_EV_DONE
    } state_t;

    // Request to the shared fixed-point multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a_mag;
        logic [63:0] b_mag;
        logic        neg;
    } mul_req_t;

    // Response of the shared fixed-point multiplier.
    typedef struct packed {
        logic        done;
        logic [63:0] mag;
        logic [63:0] value;
        logic        neg;
        logic        sat;
    } mul_rsp_t;

endpackage

// File: src/nfi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module nfi_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/nfi_mulq.sv
// Iterative fixed-point multiplier: rounded, saturated product of two magnitudes.
module nfi_mulq #(
    parameter int FRACTION_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  nfi_pkg::mul_req_t req,
    output nfi_pkg::mul_rsp_t rsp
);
    import nfi_pkg::*;

    localparam logic [127:0] HALF = 128'(1) << (FRACTION_BITS - 1);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  prod_reg;
    logic [2:0]   phase_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  mag_reg;
    logic [63:0]  value_reg;
    logic         rneg_reg;
    logic         sat_reg;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [6:0]   add_shift;
    logic [127:0] add_term;
    logic [63:0]  q_raw;
    logic         q_over;
    logic [63:0]  q_mag;

    // Pick the 32-bit halves for this phase and the offset of the previous partial.
    always_comb begin
        case (phase_reg)
            3'd0: begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            3'd1: begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
            3'd2: begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            3'd3: begin
                op_a = a_reg[63:32];
                op_b = b_reg[63:32];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        case (phase_reg)
            3'd2, 3'd3: add_shift = 7'd32;
            3'd4:       add_shift = 7'd64;
            default:    add_shift = 7'd0;
        endcase
        add_term = 128'(prod_reg) << add_shift;
    end

    // Drop the fraction bits of the rounded product and clamp it.
    always_comb begin
        q_raw  = acc_reg[FRACTION_BITS +: 64];
        q_over = ((acc_reg >> (64 + FRACTION_BITS)) != '0) || (q_raw > WIDE_LIMIT);
        q_mag  = q_over ? WIDE_LIMIT : q_raw;
    end

    // Sequencing: four partial products, one last accumulate, then the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg  <= 1'b1;
                    phase_reg <= '0;
                end
            end else begin
                phase_reg <= phase_reg + 3'd1;
                if (phase_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand, partial product and result words.
    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            if (req.start) begin
                a_reg   <= req.a_mag;
                b_reg   <= req.b_mag;
                neg_reg <= req.neg;
                acc_reg <= HALF;
            end
        end else begin
            if (phase_reg < 3'd4) begin
                prod_reg <= op_a * op_b;
            end
            if ((phase_reg >= 3'd1) && (phase_reg <= 3'd4)) begin
                acc_reg <= acc_reg + add_term;
            end
            if (phase_reg == 3'd5) begin
                mag_reg   <= q_mag;
                value_reg <= neg_reg ? (64'd0 - q_mag) : q_mag;
                rneg_reg  <= neg_reg;
                sat_reg   <= q_over;
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.mag   = mag_reg;
    assign rsp.value = value_reg;
    assign rsp.neg   = rneg_reg;
    assign rsp.sat   = sat_reg;

endmodule

// File: src/newton_forward_interpolator.sv
// Top level of the Newton forward-difference interpolator.
//
// Input words arrive on s_tvalid/s_tready; s_tuser holds the command (load a
// sample, evaluate at a query point, clear the samples), s_tdata the sample
// value in bits 31:0 and the query point in bits 63:32. Only an evaluate
// produces a word on m_tvalid/m_tready: the value in m_tdata, the status in
// m_tuser. Configuration is written through cfg_we/cfg_index/cfg_wdata.
// A load of a sample walks the difference diagonal through its RAM one entry
// at a time, a read state and a write state per entry. An evaluate is paced
// by the shared iterative multiplier: each multiply is four 32x32 partial
// products, three multiplies per term. An evaluate with too few samples
// goes straight to the result state. One word is processed at a time.
// Synchronous reset clears the sample count and the configuration to
// point_count 2, x_origin 0 and a step reciprocal of one; RAM contents are
// left as they are. A finished result waits in the output register while
// loads and clears are still accepted; a second evaluate holds in its last
// state until the waiting result is taken.
module newton_forward_interpolator #(
    parameter int MAX_POINTS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] sample_value, [63:32] query_point
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] interpolated_value
    output logic [1:0]  m_tuser     // [1:0] status
);
    import nfi_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PCW   = (CNT_W > 5) ? CNT_W : 5;
    localparam logic signed [64:0] POS_LIM = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] NEG_LIM = -POS_LIM;

    // Clamp a 33-bit signed value to 32 bits.
    function automatic logic [31:0] sat32_33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Magnitude of a 64-bit signed value.
    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Configuration registers.
    logic [4:0]  point_count_reg;
    logic [31:0] x_origin_reg;
    logic [30:0] step_recip_reg;

    // Control state.
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] loaded_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] last_reg;
    logic             m_tvalid_reg;

    // Datapath words.
    logic [31:0]        cur_reg;
    logic signed [63:0] s_reg;
    logic signed [63:0] p_reg;
    logic signed [63:0] d_reg;
    logic signed [63:0] factor_reg;
    logic               sat_reg;
    logic               few_reg;
    logic [31:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // Handshake and decode.
    logic             s_acc;
    logic             is_eval;
    logic             is_load;
    logic             is_clear;
    logic             enough;
    logic             j_at_end;
    logic             out_load;
    logic [PCW-1:0]   m_terms;
    logic [IDX_W-1:0] last_idx;

    // Arithmetic helpers.
    logic [32:0]        q_diff;
    logic [32:0]        q_mag;
    logic [32:0]        lead_mag;
    logic signed [64:0] fact_sum;
    logic signed [64:0] d_sum;
    logic [63:0]        fact_sat;
    logic               fact_over;
    logic [63:0]        d_sat;
    logic               d_over;
    logic               d_fits32;
    logic [31:0]        d_clamped;

    // RAM ports.
    logic             diag_we;
    logic             diag_re;
    logic [31:0]      diag_rdata;
    logic             lead_we;
    logic             lead_re;
    logic [IDX_W-1:0] lead_raddr;
    logic [31:0]      lead_rdata;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // Reciprocal table, entry i = round(2^FRACTION_BITS / i).
    logic [FRACTION_BITS:0] inv_table [MAX_POINTS];

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_inv
        if (g == 0) begin : g_zero
            assign inv_table[g] = '0;
        end else begin : g_entry
            localparam logic [FRACTION_BITS:0] INV_VALUE =
                (FRACTION_BITS + 1)'(((64'(1) << FRACTION_BITS) + 64'(g >> 1)) / 64'(g));
            assign inv_table[g] = INV_VALUE;
        end
    end

    nfi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_diag_ram (
        .aclk  (aclk),
        .we    (diag_we),
        .waddr (j_reg),
        .wdata (cur_reg),
        .re    (diag_re),
        .raddr (j_reg),
        .rdata (diag_rdata)
    );

    nfi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_lead_ram (
        .aclk  (aclk),
        .we    (lead_we),
        .waddr (j_reg),
        .wdata (cur_reg),
        .re    (lead_re),
        .raddr (lead_raddr),
        .rdata (lead_rdata)
    );

    nfi_mulq #(.FRACTION_BITS(FRACTION_BITS)) u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // Input decode and the number of terms used by an evaluate.
    always_comb begin
        s_acc    = s_tvalid && s_tready;
        is_eval  = (s_tuser == CMD_EVAL);
        is_load  = (s_tuser == CMD_LOAD);
        is_clear = (s_tuser == CMD_CLEAR);
        enough   = (loaded_reg >= CNT_W'(2));
        j_at_end = (CNT_W'(j_reg) == loaded_reg);
        out_load = !m_tvalid_reg || m_tready;
        m_terms  = PCW'(point_count_reg);
        if (m_terms < PCW'(2)) begin
            m_terms = PCW'(2);
        end
        if (m_terms > PCW'(MAX_POINTS)) begin
            m_terms = PCW'(MAX_POINTS);
        end
        if (m_terms > PCW'(loaded_reg)) begin
            m_terms = PCW'(loaded_reg);
        end
        last_idx = IDX_W'(m_terms - PCW'(1));
    end

    // Signed arithmetic of the evaluate steps.
    always_comb begin
        q_diff    = {s_tdata[63], s_tdata[63:32]} - {x_origin_reg[31], x_origin_reg};
        q_mag     = q_diff[32] ? (33'd0 - q_diff) : q_diff;
        lead_mag  = lead_rdata[31] ? (33'd0 - {1'b1, lead_rdata}) : {1'b0, lead_rdata};
        fact_sum  = {s_reg[63], s_reg}
                  - $signed(65'(IDX_W'(i_reg - IDX_W'(1))) << FRACTION_BITS);
        fact_over = (fact_sum > POS_LIM) || (fact_sum < NEG_LIM);
        fact_sat  = (fact_sum > POS_LIM) ? 64'(POS_LIM) :
                    (fact_sum < NEG_LIM) ? 64'(NEG_LIM) : fact_sum[63:0];
        d_sum     = {d_reg[63], d_reg} + {mul_rsp.value[63], mul_rsp.value};
        d_over    = (d_sum > POS_LIM) || (d_sum < NEG_LIM);
        d_sat     = (d_sum > POS_LIM) ? 64'(POS_LIM) :
                    (d_sum < NEG_LIM) ? 64'(NEG_LIM) : d_sum[63:0];
        d_fits32  = (d_reg[63:31] == '0) || (d_reg[63:31] == '1);
        d_clamped = d_fits32 ? d_reg[31:0] : (d_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (is_load && (loaded_reg < CNT_W'(MAX_POINTS))) begin
                        state_next = ST_LD_READ;
                    end else if (is_eval) begin
                        state_next = enough ? ST_EV_SMUL : ST_EV_DONE;
                    end
                end
            end
            ST_LD_READ:  state_next = j_at_end ? ST_IDLE : ST_LD_WRITE;
            ST_LD_WRITE: state_next = ST_LD_READ;
            ST_EV_SMUL:  state_next = mul_rsp.done ? ST_EV_FACT : ST_EV_SMUL;
            ST_EV_FACT:  state_next = ST_EV_PF;
            ST_EV_PF:    state_next = ST_EV_PF_W;
            ST_EV_PF_W:  state_next = mul_rsp.done ? ST_EV_PI_W : ST_EV_PF_W;
            ST_EV_PI_W:  state_next = mul_rsp.done ? ST_EV_PL_W : ST_EV_PI_W;
            ST_EV_PL_W: begin
                if (mul_rsp.done) begin
                    state_next = (i_reg == last_reg) ? ST_EV_DONE : ST_EV_FACT;
                end
            end
            ST_EV_DONE:  state_next = out_load ? ST_IDLE : ST_EV_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory, multiplier and handshake controls.
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        diag_we       = 1'b0;
        diag_re       = 1'b0;
        lead_we       = 1'b0;
        lead_re       = 1'b0;
        lead_raddr    = i_reg;
        mul_req.start = 1'b0;
        mul_req.a_mag = '0;
        mul_req.b_mag = '0;
        mul_req.neg   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                lead_raddr = '0;
                if (s_acc && is_eval && enough) begin
                    lead_re       = 1'b1;
                    mul_req.start = 1'b1;
                    mul_req.a_mag = 64'(q_mag);
                    mul_req.b_mag = 64'(step_recip_reg);
                    mul_req.neg   = q_diff[32];
                end
            end
            ST_LD_READ: begin
                if (j_at_end) begin
                    diag_we = 1'b1;
                    lead_we = 1'b1;
                end else begin
                    diag_re = 1'b1;
                end
            end
            ST_LD_WRITE: begin
                diag_we = 1'b1;
            end
            ST_EV_FACT: begin
                lead_re = 1'b1;
            end
            ST_EV_PF: begin
                mul_req.start = 1'b1;
                mul_req.a_mag = abs64(p_reg);
                mul_req.b_mag = abs64(factor_reg);
                mul_req.neg   = p_reg[63] ^ factor_reg[63];
            end
            ST_EV_PF_W: begin
                mul_req.start = mul_rsp.done;
                mul_req.a_mag = mul_rsp.mag;
                mul_req.b_mag = 64'(inv_table[i_reg]);
                mul_req.neg   = mul_rsp.neg;
            end
            ST_EV_PI_W: begin
                mul_req.start = mul_rsp.done;
                mul_req.a_mag = mul_rsp.mag;
                mul_req.b_mag = 64'(lead_mag);
                mul_req.neg   = mul_rsp.neg ^ lead_rdata[31];
            end
            default: begin
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            loaded_reg      <= '0;
            j_reg           <= '0;
            i_reg           <= '0;
            m_tvalid_reg    <= 1'b0;
            point_count_reg <= 5'd2;
            x_origin_reg    <= '0;
            step_recip_reg  <= 31'(1) << FRACTION_BITS;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_POINT_COUNT: point_count_reg <= cfg_wdata[4:0];
                    REG_X_ORIGIN:    x_origin_reg    <= cfg_wdata;
                    REG_STEP_RECIP:  step_recip_reg  <= cfg_wdata[30:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_IDLE && s_acc) begin
                if (is_clear) begin
                    loaded_reg <= '0;
                end
                j_reg <= '0;
            end
            if (state_reg == ST_LD_READ && j_at_end) begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (state_reg == ST_LD_WRITE) begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (state_reg == ST_EV_SMUL) begin
                i_reg <= IDX_W'(1);
            end
            if (state_reg == ST_EV_PL_W && mul_rsp.done && i_reg != last_reg) begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (state_reg == ST_EV_DONE && out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath words of the load walk and the evaluate loop.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cur_reg  <= s_tdata[31:0];
                    last_reg <= last_idx;
                    few_reg  <= !enough;
                    sat_reg  <= 1'b0;
                    d_reg    <= '0;
                end
            end
            ST_LD_WRITE: begin
                cur_reg <= sat32_33({cur_reg[31], cur_reg} - {diag_rdata[31], diag_rdata});
            end
            ST_EV_SMUL: begin
                if (mul_rsp.done) begin
                    s_reg   <= mul_rsp.value;
                    sat_reg <= sat_reg | mul_rsp.sat;
                    d_reg   <= {{32{lead_rdata[31]}}, lead_rdata};
                    p_reg   <= 64'(1) << FRACTION_BITS;
                end
            end
            ST_EV_FACT: begin
                factor_reg <= fact_sat;
                sat_reg    <= sat_reg | fact_over;
            end
            ST_EV_PF_W: begin
                if (mul_rsp.done) begin
                    sat_reg <= sat_reg | mul_rsp.sat;
                end
            end
            ST_EV_PI_W: begin
                if (mul_rsp.done) begin
                    p_reg   <= mul_rsp.value;
                    sat_reg <= sat_reg | mul_rsp.sat;
                end
            end
            ST_EV_PL_W: begin
                if (mul_rsp.done) begin
                    d_reg   <= d_sat;
                    sat_reg <= sat_reg | mul_rsp.sat | d_over;
                end
            end
            ST_EV_DONE: begin
                if (out_load) begin
                    if (few_reg) begin
                        m_tdata_reg <= '0;
                        m_tuser_reg <= STATUS_FEW;
                    end else begin
                        m_tdata_reg <= d_clamped;
                        m_tuser_reg <= (sat_reg || !d_fits32) ? STATUS_SAT : STATUS_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // The sample count never passes the store depth.
    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CNT_W'(MAX_POINTS))
        else $error("sample count exceeds store depth");

    // Leading differences are written only at the end of a load walk.
    a_lead_write: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_we |-> (state_reg == ST_LD_READ && j_at_end))
        else $error("leading difference written outside a load");

    // An evaluate with too few samples goes straight to the result.
    a_few_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_eval && !enough) |=> (state_reg == ST_EV_DONE && few_reg))
        else $error("short evaluate did not go to the result");

    // A result word appears only out of the result state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EV_DONE))
        else $error("result word from an unexpected state");

    // The multiplier is started only where the sequence expects it to be free.
    a_mul_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_req.start |-> (state_reg == ST_IDLE || state_reg == ST_EV_PF ||
                           state_reg == ST_EV_PF_W || state_reg == ST_EV_PI_W))
        else $error("multiplier started in a wrong state");
`endif

endmodule
